@@ sv/xtae_pkg.sv @@
package xtae_pkg;

	localparam int MODE_W = 2;
	localparam int IDX_W  = 3;

	localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUOT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_APOS  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TEXT3 = 2'd3;

	localparam logic [7:0] CHR_LT   = 8'h3C;
	localparam logic [7:0] CHR_GT   = 8'h3E;
	localparam logic [7:0] CHR_AMP  = 8'h26;
	localparam logic [7:0] CHR_QUOT = 8'h22;
	localparam logic [7:0] CHR_APOS = 8'h27;
	localparam logic [7:0] CHR_RBR  = 8'h5D;

	// entity texts, left aligned in six bytes
	localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
	localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};
	localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
	localparam logic [47:0] ENT_QUOT = "&quot;";
	localparam logic [47:0] ENT_APOS = "&apos;";

	// what an item turns into on the output
	typedef enum logic [2:0] {
		CODE_PASS,
		CODE_LT,
		CODE_AMP,
		CODE_GT,
		CODE_QUOT,
		CODE_APOS,
		CODE_ERR
	} code_t;

	function automatic logic [IDX_W-1:0] code_len(input code_t code);
		logic [IDX_W-1:0] len;
		case (code)
			CODE_LT:   len = 3'd4;
			CODE_GT:   len = 3'd4;
			CODE_AMP:  len = 3'd5;
			CODE_QUOT: len = 3'd6;
			CODE_APOS: len = 3'd6;
			default:   len = 3'd1;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] ent_char(input code_t code, input logic [IDX_W-1:0] idx);
		logic [47:0] txt;
		logic [IDX_W-1:0] pos;
		case (code)
			CODE_LT:   txt = ENT_LT;
			CODE_GT:   txt = ENT_GT;
			CODE_AMP:  txt = ENT_AMP;
			CODE_QUOT: txt = ENT_QUOT;
			CODE_APOS: txt = ENT_APOS;
			default:   txt = '0;
		endcase
		pos = 3'd5 - idx;
		return txt[8*pos +: 8];
	endfunction

endpackage

@@ sv/xml_text_attribute_escaper_core.sv @@
// escapes a utf-8 byte stream for xml: '<' and '&' always become entity
// references, '>' after two raw ']' bytes becomes &gt; in text mode, and the
// selected quote mark becomes &quot; or &apos; in attribute mode; all other
// bytes pass unchanged. a byte that passes through or fails the utf-8 check
// gives one item, so plain text streams at one item per clock unless out_stall
// holds it; an escaped byte gives as many items as its entity is long (4 to 6),
// which is the one output register being the only write port for results,
// and the input stalls meanwhile. a byte goes through the input stage, then
// the output register. once malformed or truncated utf-8 is seen, that byte and
// the rest of the string each give one item with has_data low and utf8_error
// high. all string state clears after the item marked end_of_string.
// escape_mode must only be written while the block is idle.
module xml_text_attribute_escaper_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [xtae_pkg::MODE_W-1:0] cfg_data,
	// raw byte input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        end_of_string,
	// escaped byte output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        has_data,
	output logic                        run_last,
	output logic                        string_end,
	output logic                        utf8_error
);
	import xtae_pkg::*;

	logic [MODE_W-1:0] mode_q;

	// input stage
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eos_s1;
	code_t             code_s1;
	logic [IDX_W-1:0]  idx_q;

	// output register
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              has_data_q;
	logic              run_last_q;
	logic              string_end_q;
	logic              utf8_error_q;

	code_t             code_in;
	logic              in_accept;
	logic              out_load;
	logic              s1_last;
	logic              s1_done;
	logic [7:0]        char_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// utf-8 check and escape decision, made as the item is taken
	xtae_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.escape_mode   (mode_q),
		.code          (code_in)
	);

	// the output register takes a new byte whenever it is empty or draining
	assign out_load  = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_last   = (idx_q == code_len(code_s1) - 3'd1);
	assign s1_done   = out_load && s1_last;
	assign in_stall  = valid_s1 && !s1_done;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		case (code_s1)
			CODE_PASS: char_s1 = byte_s1;
			CODE_ERR:  char_s1 = 8'h00;
			default:   char_s1 = ent_char(code_s1, idx_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_accept) valid_s1 <= 1'b1;
			else if (s1_done) valid_s1 <= 1'b0;
			// walk through the entity text one byte per output item
			if (out_load) idx_q <= s1_last ? '0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_string;
			code_s1 <= code_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q   <= char_s1;
			has_data_q   <= (code_s1 != CODE_ERR);
			run_last_q   <= s1_last;
			string_end_q <= s1_last && eos_s1;
			utf8_error_q <= (code_s1 == CODE_ERR);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign has_data   = has_data_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;
	assign utf8_error = utf8_error_q;

	// an error item is a single empty item
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && utf8_error |-> run_last && !has_data && out_byte == 8'h00)
		else $error("error item carries data");

	// end of string only on the final item of a byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> run_last)
		else $error("string_end without run_last");

	// an entity in progress keeps its input item and blocks the input until its last byte
	a_mid_entity: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> valid_s1 && (in_stall || s1_last))
		else $error("entity index moved without an item");

	// a loaded item that is not the last of its byte leaves the stage held
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !s1_last |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost an item mid entity");

endmodule

@@ sv/xtae_classify.sv @@
module xtae_classify (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [7:0]                     in_byte,
	input  logic                           end_of_string,
	input  logic [xtae_pkg::MODE_W-1:0]    escape_mode,
	output xtae_pkg::code_t                code
);
	import xtae_pkg::*;

	// utf-8 check state and ]] tracking
	logic [1:0]  cont_q;
	logic [14:0] part_q;
	logic [1:0]  brun_q;
	logic        err_q;

	logic [1:0]  cont_d;
	logic [14:0] part_d;
	logic [1:0]  brun_d;
	logic        bad;
	logic [14:0] np;
	logic        text;

	always_comb begin
		np     = {part_q[8:0], in_byte[5:0]};
		cont_d = cont_q;
		part_d = part_q;
		bad    = 1'b0;
		if (cont_q == 2'd0) begin
			if (in_byte < 8'h80) begin
				part_d = {7'd0, in_byte};
			end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
				cont_d = 2'd1;
				part_d = {10'd0, in_byte[4:0]};
			end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
				cont_d = 2'd2;
				part_d = {11'd0, in_byte[3:0]};
			end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
				cont_d = 2'd3;
				part_d = {12'd0, in_byte[2:0]};
			end else begin
				bad = 1'b1;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			bad = 1'b1;
		end else begin
			// overlong, surrogate and out-of-range checks on the first continuation
			if (cont_q == 2'd3) begin
				if (np < 15'h10 || np > 15'h10F) bad = 1'b1;
			end else if (cont_q == 2'd2 && part_q < 15'h10) begin
				if (np < 15'h20 || (np >= 15'h360 && np <= 15'h37F)) bad = 1'b1;
			end
			part_d = np;
			cont_d = cont_q - 2'd1;
		end
		// truncated character at end of string
		if (!bad && end_of_string && cont_d != 2'd0) bad = 1'b1;
	end

	always_comb begin
		text = (escape_mode == MODE_TEXT) || (escape_mode == MODE_TEXT3);
		if (err_q || bad)                                    code = CODE_ERR;
		else if (in_byte == CHR_LT)                          code = CODE_LT;
		else if (in_byte == CHR_AMP)                         code = CODE_AMP;
		else if (in_byte == CHR_GT && text && brun_q == 2'd2) code = CODE_GT;
		else if (in_byte == CHR_QUOT && escape_mode == MODE_QUOT) code = CODE_QUOT;
		else if (in_byte == CHR_APOS && escape_mode == MODE_APOS) code = CODE_APOS;
		else                                                 code = CODE_PASS;
	end

	always_comb begin
		if (in_byte != CHR_RBR) brun_d = 2'd0;
		else if (brun_q == 2'd2) brun_d = 2'd2;
		else brun_d = brun_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= '0;
			part_q <= '0;
			brun_q <= '0;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_string) begin
				cont_q <= '0;
				part_q <= '0;
				brun_q <= '0;
				err_q  <= 1'b0;
			end else if (!err_q) begin
				if (bad) begin
					err_q <= 1'b1;
				end else begin
					cont_q <= cont_d;
					part_q <= part_d;
					brun_q <= brun_d;
				end
			end
		end
	end

endmodule

@@ bench/xml_text_attribute_escaper_core_tb.sv @@
`timescale 1ns / 100ps

module xml_text_attribute_escaper_core_tb;
	import xtae_pkg::*;

	// cycles with no handshake on any channel before the run is declared hung
	localparam int STALL_LIMIT = 200;
	// settling time after the last escaped byte has been seen
	localparam int END_CYCLES = 8;
	localparam int RAND_ITEMS = 350;

	// one escaped output byte as the block presents it
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic       run_last;
		logic       string_end;
		logic       utf8_error;
	} result_t;

	// how a directed row is checked: against the predictor, or against a result
	// that is obvious from the row itself (byte copied, or the error item)
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_PASS,
		CHK_ERR
	} row_chk_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [7:0]        b;
		logic              eos;
		row_chk_t          chk;
	} dir_row_t;

	// directed strings, grouped by escape mode
	localparam dir_row_t DIRECTED [27] = '{
		// text mode right after reset: nul, '<', "]]>", '&' closing the string
		'{MODE_TEXT,  8'h00,    1'b0, CHK_PASS},
		'{MODE_TEXT,  CHR_LT,   1'b0, CHK_MODEL},
		'{MODE_TEXT,  CHR_RBR,  1'b0, CHK_PASS},
		'{MODE_TEXT,  CHR_RBR,  1'b0, CHK_PASS},
		'{MODE_TEXT,  CHR_GT,   1'b0, CHK_MODEL},
		'{MODE_TEXT,  CHR_AMP,  1'b1, CHK_MODEL},
		// stray continuation byte, then the error sticks to the end of the string
		'{MODE_TEXT,  8'h80,    1'b0, CHK_ERR},
		'{MODE_TEXT,  8'h41,    1'b1, CHK_ERR},
		// ascii where a continuation byte belongs
		'{MODE_TEXT,  8'hC3,    1'b0, CHK_PASS},
		'{MODE_TEXT,  8'h41,    1'b1, CHK_ERR},
		// string ends inside a character
		'{MODE_TEXT,  8'hC3,    1'b1, CHK_ERR},
		// overlong three-byte form
		'{MODE_TEXT,  8'hE0,    1'b0, CHK_PASS},
		'{MODE_TEXT,  8'h9F,    1'b1, CHK_ERR},
		// surrogate
		'{MODE_TEXT,  8'hED,    1'b0, CHK_PASS},
		'{MODE_TEXT,  8'hA0,    1'b1, CHK_ERR},
		// overlong four-byte form
		'{MODE_TEXT,  8'hF0,    1'b0, CHK_PASS},
		'{MODE_TEXT,  8'h8F,    1'b1, CHK_ERR},
		// code point above the unicode range
		'{MODE_TEXT,  8'hF4,    1'b0, CHK_PASS},
		'{MODE_TEXT,  8'h90,    1'b1, CHK_ERR},
		// lead byte that never occurs
		'{MODE_TEXT,  8'hFF,    1'b1, CHK_ERR},
		// double-quoted attribute: '"' is escaped, '\'' passes
		'{MODE_QUOT,  CHR_QUOT, 1'b0, CHK_MODEL},
		'{MODE_QUOT,  CHR_APOS, 1'b1, CHK_PASS},
		// apostrophe attribute: '\'' is escaped, '"' passes
		'{MODE_APOS,  CHR_APOS, 1'b0, CHK_MODEL},
		'{MODE_APOS,  CHR_QUOT, 1'b1, CHK_PASS},
		// mode three acts as text mode
		'{MODE_TEXT3, CHR_RBR,  1'b0, CHK_PASS},
		'{MODE_TEXT3, CHR_RBR,  1'b0, CHK_PASS},
		'{MODE_TEXT3, CHR_GT,   1'b1, CHK_MODEL}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [MODE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        in_byte;
	logic              end_of_string;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        out_byte;
	logic              has_data;
	logic              run_last;
	logic              string_end;
	logic              utf8_error;

	// escaped bytes still to come, oldest first
	result_t pending_escapes[$];
	// what the last predicted input byte turns into
	result_t escape_run[$];
	// raw bytes of the next random string
	logic [7:0] raw_string[$];

	// predictor copy of the block's register and per-string state
	logic [MODE_W-1:0] esc_mode;
	logic [1:0]        cont_need;
	logic [20:0]       cp_acc;
	logic [1:0]        rbr_run;
	logic              bad_seen;

	int errors;
	int sent_items;
	int idle_cycles;
	bit in_calm;

	xml_text_attribute_escaper_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_data      (has_data),
		.run_last      (run_last),
		.string_end    (string_end),
		.utf8_error    (utf8_error)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic string entity_of(input code_t code);
		case (code)
			CODE_LT:   return "&lt;";
			CODE_GT:   return "&gt;";
			CODE_AMP:  return "&amp;";
			CODE_QUOT: return "&quot;";
			CODE_APOS: return "&apos;";
			default:   return "";
		endcase
	endfunction

	// utf-8 check and escaping of one raw byte; fills escape_run
	task automatic predict_escape(input logic [7:0] b, input logic eos);
		logic        bad;
		logic [20:0] next_cp;
		logic        text;
		code_t       code;
		string       ent;
		int          i;
		escape_run.delete();
		if (!bad_seen) begin
			bad = 1'b0;
			if (cont_need == 2'd0) begin
				// lead byte
				if (b < 8'h80) begin
					cp_acc = {13'd0, b};
				end else if (b >= 8'hC2 && b <= 8'hDF) begin
					cont_need = 2'd1;
					cp_acc = {16'd0, b[4:0]};
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					cont_need = 2'd2;
					cp_acc = {17'd0, b[3:0]};
				end else if (b >= 8'hF0 && b <= 8'hF4) begin
					cont_need = 2'd3;
					cp_acc = {18'd0, b[2:0]};
				end else begin
					bad = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				next_cp = {cp_acc[14:0], b[5:0]};
				// range checks happen on the first continuation byte
				if (cont_need == 2'd3) begin
					if (next_cp < 21'h10 || next_cp > 21'h10F)
						bad = 1'b1;
				end else if (cont_need == 2'd2 && cp_acc < 21'h10) begin
					if (next_cp < 21'h20 || (next_cp >= 21'h360 && next_cp <= 21'h37F))
						bad = 1'b1;
				end
				if (!bad) begin
					cp_acc = next_cp;
					cont_need = cont_need - 2'd1;
				end
			end
			// string closed in the middle of a character
			if (!bad && eos && cont_need != 2'd0)
				bad = 1'b1;
			if (bad)
				bad_seen = 1'b1;
		end

		if (bad_seen) begin
			escape_run.push_back('{8'h00, 1'b0, 1'b1, eos, 1'b1});
		end else begin
			text = (esc_mode == MODE_TEXT || esc_mode == MODE_TEXT3);
			code = CODE_PASS;
			if (b == CHR_LT)
				code = CODE_LT;
			else if (b == CHR_AMP)
				code = CODE_AMP;
			else if (b == CHR_GT && text && rbr_run == 2'd2)
				code = CODE_GT;
			else if (b == CHR_QUOT && esc_mode == MODE_QUOT)
				code = CODE_QUOT;
			else if (b == CHR_APOS && esc_mode == MODE_APOS)
				code = CODE_APOS;

			if (code == CODE_PASS) begin
				escape_run.push_back('{b, 1'b1, 1'b1, eos, 1'b0});
			end else begin
				ent = entity_of(code);
				for (i = 0; i < ent.len(); i++)
					escape_run.push_back('{ent[i], 1'b1, i == ent.len() - 1,
						(i == ent.len() - 1) && eos, 1'b0});
			end
			rbr_run = (b == CHR_RBR) ? ((rbr_run < 2'd2) ? rbr_run + 2'd1 : 2'd2) : 2'd0;
		end

		if (eos) begin
			cont_need = 2'd0;
			cp_acc = '0;
			rbr_run = 2'd0;
			bad_seen = 1'b0;
		end
	endtask

	// offer one raw byte, wait for it to be taken, then record what must come out
	task automatic send_item(input logic [7:0] b, input logic eos, input row_chk_t chk);
		int unsigned gap;
		gap = in_calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_string <= eos;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_escape(b, eos);
		case (chk)
			CHK_PASS: pending_escapes.push_back('{b, 1'b1, 1'b1, eos, 1'b0});
			CHK_ERR:  pending_escapes.push_back('{8'h00, 1'b0, 1'b1, eos, 1'b1});
			default:  foreach (escape_run[i]) pending_escapes.push_back(escape_run[i]);
		endcase
		sent_items++;
	endtask

	// hold the input until every escaped byte is out, then load a new mode;
	// every byte yields at least one item, so an empty queue means idle
	task automatic set_mode(input logic [MODE_W-1:0] m);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_escapes.size() != 0);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		esc_mode = m;
	endtask

	// random string: mostly valid utf-8 with markup characters mixed in,
	// some damaged, a few pure noise
	task automatic build_string();
		int unsigned n_chars, k, cp, pos;
		raw_string.delete();
		n_chars = $urandom_range(1, 10);
		for (k = 0; k < n_chars; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: cp = $urandom_range(0, 127);
				3, 4: begin
					case ($urandom_range(0, 5))
						0: cp = 32'(CHR_LT);
						1: cp = 32'(CHR_AMP);
						2: cp = 32'(CHR_GT);
						3: cp = 32'(CHR_QUOT);
						4: cp = 32'(CHR_APOS);
						default: cp = 32'(CHR_RBR);
					endcase
				end
				5: cp = $urandom_range('h80, 'h7FF);
				6: begin
					cp = $urandom_range('h800, 'hFFFF);
					// step out of the surrogate block
					if (cp >= 'hD800 && cp <= 'hDFFF)
						cp = cp ^ 'h1000;
				end
				7: cp = $urandom_range('h10000, 'h10FFFF);
				8: begin
					// boundaries of the encoding lengths
					case ($urandom_range(0, 8))
						0: cp = 'h7F;
						1: cp = 'h80;
						2: cp = 'h7FF;
						3: cp = 'h800;
						4: cp = 'hD7FF;
						5: cp = 'hE000;
						6: cp = 'hFFFF;
						7: cp = 'h10000;
						default: cp = 'h10FFFF;
					endcase
				end
				default: begin
					// bracket run leading into '>'
					raw_string.push_back(CHR_RBR);
					if ($urandom_range(0, 3) != 0)
						raw_string.push_back(CHR_RBR);
					cp = 32'(CHR_GT);
				end
			endcase
			if (cp < 'h80) begin
				raw_string.push_back(cp[7:0]);
			end else if (cp < 'h800) begin
				raw_string.push_back({3'b110, cp[10:6]});
				raw_string.push_back({2'b10, cp[5:0]});
			end else if (cp < 'h10000) begin
				raw_string.push_back({4'b1110, cp[15:12]});
				raw_string.push_back({2'b10, cp[11:6]});
				raw_string.push_back({2'b10, cp[5:0]});
			end else begin
				raw_string.push_back({5'b11110, cp[20:18]});
				raw_string.push_back({2'b10, cp[17:12]});
				raw_string.push_back({2'b10, cp[11:6]});
				raw_string.push_back({2'b10, cp[5:0]});
			end
		end

		case ($urandom_range(0, 19))
			0, 1: begin
				// overwrite one byte
				pos = $urandom_range(0, raw_string.size() - 1);
				raw_string[pos] = 8'($urandom_range(0, 255));
			end
			2: begin
				// cut the last byte off, or end on a bare lead byte
				if (raw_string.size() > 1)
					void'(raw_string.pop_back());
				else
					raw_string[0] = 8'($urandom_range('hC2, 'hF4));
			end
			3: begin
				pos = $urandom_range(0, raw_string.size());
				raw_string.insert(pos, 8'($urandom_range(0, 255)));
			end
			4: begin
				raw_string.delete();
				repeat ($urandom_range(1, 6))
					raw_string.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	// stimulus and end of run
	initial begin
		int r, p;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= MODE_TEXT;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		end_of_string <= 1'b0;
		esc_mode = MODE_TEXT;
		cont_need = 2'd0;
		cp_acc = '0;
		rbr_run = 2'd0;
		bad_seen = 1'b0;
		errors = 0;
		sent_items = 0;
		in_calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings; a mode change waits for the block to drain
		for (r = 0; r < $size(DIRECTED); r++) begin
			if (DIRECTED[r].mode != esc_mode)
				set_mode(DIRECTED[r].mode);
			send_item(DIRECTED[r].b, DIRECTED[r].eos, DIRECTED[r].chk);
		end

		// random strings, with occasional drained mode changes
		set_mode(MODE_TEXT);
		sent_items = 0;
		while (sent_items < RAND_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				set_mode(MODE_W'($urandom_range(0, 3)));
			in_calm = ($urandom_range(0, 4) == 0);
			build_string();
			for (p = 0; p < raw_string.size(); p++)
				send_item(raw_string[p], p == raw_string.size() - 1, CHK_MODEL);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_escapes.size() != 0);
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// output side: random stall per item, with calm stretches; compare each
	// item against the oldest expectation
	initial begin
		result_t want;
		int unsigned hold;
		bit calm;
		calm = 1'b0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				calm = !calm;
			hold = calm ? 0 : $urandom_range(0, 3);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
			if (pending_escapes.size() == 0) begin
				$error("unexpected item: out_byte %h has_data %b", out_byte, has_data);
				errors++;
			end else begin
				want = pending_escapes.pop_front();
				if (out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, out_byte);
					errors++;
				end
				if (has_data !== want.has_data) begin
					$error("has_data: expected %b, got %b", want.has_data, has_data);
					errors++;
				end
				if (run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, run_last);
					errors++;
				end
				if (string_end !== want.string_end) begin
					$error("string_end: expected %b, got %b", want.string_end, string_end);
					errors++;
				end
				if (utf8_error !== want.utf8_error) begin
					$error("utf8_error: expected %b, got %b", want.utf8_error, utf8_error);
					errors++;
				end
			end
		end
	end

	// hang detection: any handshake on any channel restarts the count
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
		    (out_valid === 1'b1 && out_stall === 1'b0) ||
		    (cfg_valid === 1'b1 && cfg_ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

@@ xml_text_attribute_escaper_core.f @@
sv/xtae_pkg.sv
sv/xtae_classify.sv
sv/xml_text_attribute_escaper_core.sv
bench/xml_text_attribute_escaper_core_tb.sv
